>>> rtl/core/smm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sparse triplet matrix multiplier.
// No dependencies; imported by every module of the block.
package smm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int MAX_TERMS  = 64;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int TERM_AW    = $clog2(MAX_TERMS);
  localparam int CNT_W      = TERM_AW + 1;
  localparam int PS_AW      = 2 * DIM_W;
  localparam int PS_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int REG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = 44;
  localparam int OUT_VAL_W  = 35;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_PAY_W  = 2 * DIM_W + OUT_VAL_W;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_MULT   = 2'd2;

  localparam logic [1:0] STAT_VALID    = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_DRAIN,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [VAL_W-1:0] value;
  } term_t;

  typedef struct packed {
    logic               we;
    logic [TERM_AW-1:0] waddr;
    term_t              wdata;
    logic               re;
    logic [TERM_AW-1:0] raddr;
  } term_ram_req_t;

  typedef struct packed {
    logic             we;
    logic [PS_AW-1:0] addr;
    logic [ACC_W-1:0] data;
  } ps_wr_t;

  typedef struct packed {
    logic [DIM_W-1:0]     row;
    logic [DIM_W-1:0]     col;
    logic [OUT_VAL_W-1:0] value;
    logic [1:0]           status;
  } res_t;

  function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] r);
    return (r > REG_W'(MAX_DIM)) ? REG_W'(MAX_DIM) : r;
  endfunction

  function automatic logic [OUT_VAL_W-1:0] sat_value(input logic [ACC_W-1:0] v);
    logic [ACC_W-OUT_VAL_W:0] hi_bits;
    hi_bits = v[ACC_W-1:OUT_VAL_W-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[OUT_VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(OUT_VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/core/smm_term_ram.sv
`timescale 1ns / 1ps
// Triplet list memory: one write port, one registered read port.
// Depends on smm_pkg.
module smm_term_ram (
  input  logic                  clk,
  input  smm_pkg::term_ram_req_t req,
  output smm_pkg::term_t        rdata
);
  import smm_pkg::*;

  term_t mem [MAX_TERMS];
  term_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/smm_prod_ram.sv
`timescale 1ns / 1ps
// Product store: 8x8 accumulator memory with per-entry valid bits.
// Invalid entries read as zero. Depends on smm_pkg.
module smm_prod_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  smm_pkg::ps_wr_t             wr,
  input  logic [smm_pkg::PS_AW-1:0]   raddr,
  output logic [smm_pkg::ACC_W-1:0]   rdata
);
  import smm_pkg::*;

  logic [ACC_W-1:0]    mem [PS_DEPTH];
  logic [PS_DEPTH-1:0] vld_r;
  logic [ACC_W-1:0]    q_r;
  logic                q_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      q_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

>>> rtl/core/smm_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate pipeline: match and multiply, then read-modify-write
// of the product store with forwarding. Depends on smm_pkg.
module smm_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  smm_pkg::term_t            a_term,
  input  smm_pkg::term_t            b_term,
  input  logic [smm_pkg::ACC_W-1:0] ps_rdata,
  output logic [smm_pkg::PS_AW-1:0] ps_raddr,
  output smm_pkg::ps_wr_t           ps_wr
);
  import smm_pkg::*;

  logic                     match;
  logic [PS_AW-1:0]         addr_s1;
  logic signed [PROD_W-1:0] prod_s1;
  logic                     v_r;
  logic                     fwd_r;
  logic [PS_AW-1:0]         addr_r;
  logic [PROD_W-1:0]        prod_r;
  logic [ACC_W-1:0]         fwd_data_r;
  logic [ACC_W-1:0]         old_val;
  logic [ACC_W-1:0]         sum;

  assign match   = (b_term.row == a_term.col);
  assign addr_s1 = {a_term.row, b_term.col};
  assign prod_s1 = $signed(a_term.value) * $signed(b_term.value);

  assign ps_raddr = addr_s1;

  // same-entry write in flight during the read: take the write data
  assign old_val = fwd_r ? fwd_data_r : ps_rdata;
  assign sum     = old_val + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign ps_wr.we   = v_r;
  assign ps_wr.addr = addr_r;
  assign ps_wr.data = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      v_r   <= s1_valid && match;
      fwd_r <= v_r && (addr_r == addr_s1);
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_s1;
    prod_r     <= prod_s1;
    fwd_data_r <= sum;
  end

endmodule

>>> rtl/core/smm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: config registers, list loads, pair walk, product scan and
// result register. Depends on smm_pkg.
module smm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smm_pkg::REG_W-1:0]      cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [smm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [smm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast,
  output smm_pkg::term_ram_req_t         a_req,
  output smm_pkg::term_ram_req_t         b_req,
  output logic                           ps_clr,
  output logic                           s1_valid,
  output logic                           scan_sel,
  output logic [smm_pkg::PS_AW-1:0]      scan_addr,
  input  logic [smm_pkg::ACC_W-1:0]      ps_rdata
);
  import smm_pkg::*;

  state_t             state_r, state_nxt;
  logic [REG_W-1:0]   a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [CNT_W-1:0]   a_cnt_r, b_cnt_r;
  logic [TERM_AW-1:0] i_r, j_r;
  logic [DIM_W-1:0]   r_r, c_r;
  logic               drain_r;
  logic               s1_valid_r;
  logic               has_pend_r;
  logic               out_vld_r;
  logic               out_last_r;
  res_t               pend_r;
  res_t               out_r;

  term_t            in_term;
  logic             accept, mult_go, mismatch, ld_a_ok, ld_b_ok;
  logic             i_last, j_last;
  logic [REG_W-1:0] nr, nc;
  logic             scan_empty, c_end, r_end, scan_last;
  logic             nz, out_free, chk_stall, chk_adv, push;

  assign in_term.row   = in_tdata[DIM_W-1:0];
  assign in_term.col   = in_tdata[2*DIM_W-1:DIM_W];
  assign in_term.value = in_tdata[2*DIM_W+VAL_W-1:2*DIM_W];

  assign accept   = in_tvalid && in_tready;
  assign mult_go  = accept && (in_tuser == ACT_MULT);
  assign mismatch = (a_cols_r != b_rows_r);
  assign ld_a_ok  = accept && (in_tuser == ACT_LOAD_A)
                    && (REG_W'(in_term.row) < a_rows_r) && (REG_W'(in_term.col) < a_cols_r)
                    && (a_cnt_r < CNT_W'(MAX_TERMS));
  assign ld_b_ok  = accept && (in_tuser == ACT_LOAD_B)
                    && (REG_W'(in_term.row) < b_rows_r) && (REG_W'(in_term.col) < b_cols_r)
                    && (b_cnt_r < CNT_W'(MAX_TERMS));

  assign i_last = ({1'b0, i_r} == a_cnt_r - CNT_W'(1));
  assign j_last = ({1'b0, j_r} == b_cnt_r - CNT_W'(1));

  assign nr         = eff_dim(a_rows_r);
  assign nc         = eff_dim(b_cols_r);
  assign scan_empty = (nr == '0) || (nc == '0);
  assign c_end      = (REG_W'(c_r) + REG_W'(1) == nc);
  assign r_end      = (REG_W'(r_r) + REG_W'(1) == nr);
  assign scan_last  = c_end && r_end;

  assign nz        = (ps_rdata != '0);
  assign out_free  = !out_vld_r || out_tready;
  assign chk_stall = (state_r == S_SCAN_CHK) && nz && has_pend_r && !out_free;
  assign chk_adv   = (state_r == S_SCAN_CHK) && !chk_stall;
  assign push      = (chk_adv && nz && has_pend_r) || ((state_r == S_FINAL) && out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (mult_go) begin
          if (mismatch) begin
            state_nxt = S_FINAL;
          end else if (a_cnt_r == '0 || b_cnt_r == '0) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_RD_A;
          end
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        if (j_last) begin
          state_nxt = i_last ? S_DRAIN : S_RD_A;
        end
      end
      S_DRAIN: begin
        if (drain_r) begin
          state_nxt = scan_empty ? S_FINAL : S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!chk_stall) begin
          state_nxt = scan_last ? S_FINAL : S_SCAN_RD;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == S_IDLE);
    a_req.we    = ld_a_ok;
    a_req.waddr = a_cnt_r[TERM_AW-1:0];
    a_req.wdata = in_term;
    a_req.re    = (state_r == S_RD_A);
    a_req.raddr = i_r;
    b_req.we    = ld_b_ok;
    b_req.waddr = b_cnt_r[TERM_AW-1:0];
    b_req.wdata = in_term;
    b_req.re    = (state_r == S_RD_B);
    b_req.raddr = j_r;
    ps_clr      = mult_go && !mismatch;
    s1_valid    = s1_valid_r;
    scan_sel    = (state_r == S_SCAN_RD) || (state_r == S_SCAN_CHK);
    scan_addr   = {r_r, c_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      a_rows_r   <= REG_W'(MAX_DIM);
      a_cols_r   <= REG_W'(MAX_DIM);
      b_rows_r   <= REG_W'(MAX_DIM);
      b_cols_r   <= REG_W'(MAX_DIM);
      a_cnt_r    <= '0;
      b_cnt_r    <= '0;
      i_r        <= '0;
      j_r        <= '0;
      r_r        <= '0;
      c_r        <= '0;
      drain_r    <= 1'b0;
      s1_valid_r <= 1'b0;
      has_pend_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_A_ROWS: a_rows_r <= cfg_data;
          REG_A_COLS: a_cols_r <= cfg_data;
          REG_B_ROWS: b_rows_r <= cfg_data;
          REG_B_COLS: b_cols_r <= cfg_data;
        endcase
      end
      if ((state_r == S_FINAL) && out_free) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end else begin
        if (ld_a_ok) begin
          a_cnt_r <= a_cnt_r + CNT_W'(1);
        end
        if (ld_b_ok) begin
          b_cnt_r <= b_cnt_r + CNT_W'(1);
        end
      end
      if (mult_go) begin
        i_r <= '0;
      end else if ((state_r == S_RD_B) && j_last) begin
        i_r <= i_r + TERM_AW'(1);
      end
      if (state_r == S_RD_A) begin
        j_r <= '0;
      end else if (state_r == S_RD_B) begin
        j_r <= j_r + TERM_AW'(1);
      end
      if (state_r == S_DRAIN) begin
        r_r <= '0;
        c_r <= '0;
      end else if (chk_adv) begin
        if (c_end) begin
          c_r <= '0;
          r_r <= r_r + DIM_W'(1);
        end else begin
          c_r <= c_r + DIM_W'(1);
        end
      end
      drain_r    <= (state_r == S_DRAIN) ? ~drain_r : 1'b0;
      s1_valid_r <= (state_r == S_RD_B);
      if (mult_go) begin
        has_pend_r <= 1'b0;
      end else if (chk_adv && nz) begin
        has_pend_r <= 1'b1;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // held result: pushed out once the next nonzero is found or the scan ends
  always_ff @(posedge clk) begin
    if (mult_go) begin
      pend_r <= '{row: '0, col: '0, value: '0, status: STAT_MISMATCH};
    end else if ((state_r == S_DRAIN) && drain_r && scan_empty) begin
      pend_r <= '{row: '0, col: '0, value: '0, status: STAT_EMPTY};
    end else if (chk_adv) begin
      if (nz) begin
        pend_r <= '{row: r_r, col: c_r, value: sat_value(ps_rdata), status: STAT_VALID};
      end else if (scan_last && !has_pend_r) begin
        pend_r <= '{row: '0, col: '0, value: '0, status: STAT_EMPTY};
      end
    end
    if (push) begin
      out_r      <= pend_r;
      out_last_r <= (state_r == S_FINAL);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_PAY_W){1'b0}}, out_r.value, out_r.col, out_r.row};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/core/sparse_triplet_matrix_multiply.sv
`timescale 1ns / 1ps
// Sparse matrix multiply on (row, column, value) triplet lists.
// Channels: in_* carries commands (tuser: load A, load B, multiply) with the
// triplet in tdata; out_* carries product nonzeros (tuser: status, tlast on
// the final result of a multiply); cfg_* writes the four dimension registers.
// In a multiply the pair walk reads one B entry per cycle from the B list
// port, pausing to fetch each A entry, and does one read-modify-write of
// the product store per matching pair; the scan then visits each product
// element in a read state and a check state on the product store read port.
// in_tready is low from a multiply until its last result is in the output
// register; loads may be taken while that result still waits.
// Mismatched inner dimensions give one status-only result; an all-zero
// product gives one empty status result. Both lists empty after a multiply.
// A stalled receiver holds the scan until the output register frees up.
// Reset (rst_n low, synchronous) empties the lists, sets all dimensions to 8
// and drops any result; no clearing pass is needed.
module sparse_triplet_matrix_multiply (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smm_pkg::REG_W-1:0]      cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [smm_pkg::IN_DATA_W-1:0]  in_tdata,   // entry_row, entry_col, entry_value
  input  logic [1:0]                     in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [smm_pkg::OUT_DATA_W-1:0] out_tdata,  // out_row, out_col, out_value
  output logic [1:0]                     out_tuser,  // status
  output logic                           out_tlast
);
  import smm_pkg::*;

  term_ram_req_t    a_req, b_req;
  term_t            a_term, b_term;
  ps_wr_t           ps_wr;
  logic             ps_clr, s1_valid, scan_sel;
  logic [PS_AW-1:0] scan_addr, mac_raddr, ps_raddr;
  logic [ACC_W-1:0] ps_rdata;

  smm_ctrl u_ctrl (
    .clk, .rst_n,
    .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .a_req, .b_req, .ps_clr, .s1_valid, .scan_sel, .scan_addr, .ps_rdata
  );

  smm_term_ram u_a_ram (.clk, .req(a_req), .rdata(a_term));
  smm_term_ram u_b_ram (.clk, .req(b_req), .rdata(b_term));

  smm_mac u_mac (
    .clk, .rst_n, .s1_valid, .a_term, .b_term, .ps_rdata,
    .ps_raddr(mac_raddr), .ps_wr
  );

  assign ps_raddr = scan_sel ? scan_addr : mac_raddr;

  smm_prod_ram u_prod (
    .clk, .rst_n, .clr(ps_clr), .wr(ps_wr), .raddr(ps_raddr), .rdata(ps_rdata)
  );

endmodule

>>> rtl/core/smm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sparse triplet matrix multiplier, bound to the
// top level. Depends on smm_pkg.
module smm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [1:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [smm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);
  import smm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_mult_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_MULT) |=> !in_tready)
    else $error("input taken right after a multiply transfer");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_VALID) |-> out_tlast)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_VALID) |-> (out_tdata == '0))
    else $error("status result carries data");

endmodule

bind sparse_triplet_matrix_multiply smm_checker u_smm_checker (.*);
